/* rtl/core/srfc_pkg.sv */
// Shared types, constants and functions for the sensor response frame checker.
// No dependencies; every other file of the block refers to this package by scoped names.
`timescale 1ns / 1ps

package srfc_pkg;

    // CRC-16, reflected form
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // byte positions within a response frame
    localparam logic [2:0] POS_COMMAND   = 3'd0;
    localparam logic [2:0] POS_LENGTH    = 3'd1;
    localparam logic [2:0] POS_HUM_HIGH  = 3'd2;
    localparam logic [2:0] POS_HUM_LOW   = 3'd3;
    localparam logic [2:0] POS_TEMP_HIGH = 3'd4;
    localparam logic [2:0] POS_TEMP_LOW  = 3'd5;
    localparam logic [2:0] POS_CRC_LOW   = 3'd6;
    localparam logic [2:0] POS_CRC_HIGH  = 3'd7;
    // bytes below this position are covered by the CRC
    localparam logic [2:0] CRC_SPAN      = 3'd6;

    // result status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_LENGTH  = 2'd1;
    localparam logic [1:0] STATUS_CRC     = 2'd2;
    localparam logic [1:0] STATUS_COMMAND = 2'd3;

    // configuration register indexes and reset values
    localparam logic CFG_EXPECTED_COMMAND = 1'b0;
    localparam logic CFG_EXPECTED_LENGTH  = 1'b1;
    localparam logic [7:0] EXPECTED_COMMAND_RESET = 8'h03;
    localparam logic [7:0] EXPECTED_LENGTH_RESET  = 8'h04;

    // complete frame, handed from the front end to the checker
    typedef struct packed {
        logic [7:0]  command;
        logic [7:0]  length;
        logic [15:0] raw_humidity;
        logic [15:0] raw_temperature;
        logic [15:0] crc_calc;
        logic [15:0] crc_recv;
    } frame_rec_t;

    // live configuration
    typedef struct packed {
        logic [7:0] expected_command;
        logic [7:0] expected_length;
    } cfg_t;

    // one byte through the reflected CRC, eight shift steps unrolled
    function automatic logic [15:0] crc16_absorb(input logic [15:0] crc,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // sign-magnitude tenths to two's complement; negative zero gives zero
    function automatic logic [15:0] decode_tenths(input logic [15:0] raw);
        logic [15:0] mag;
        mag = {1'b0, raw[14:0]};
        return raw[15] ? 16'(16'd0 - mag) : mag;
    endfunction

endpackage

/* rtl/core/srfc_front.sv */
// Front end: takes received bytes, tracks frame position, runs the CRC and
// assembles a frame record on the last byte. Depends on srfc_pkg.
`timescale 1ns / 1ps

module srfc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_accept,
    input  logic [7:0]           rx_byte,
    input  logic                 frame_start,
    output logic                 rec_push,
    output srfc_pkg::frame_rec_t rec
);

    logic [2:0]  byte_count_reg, byte_count_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  command_reg;
    logic [7:0]  length_reg;
    logic [15:0] raw_hum_reg;
    logic [15:0] raw_temp_reg;
    logic [7:0]  crc_low_reg;
    logic [2:0]  pos;
    logic [15:0] crc_base;

    // frame start forces position zero
    assign pos      = frame_start ? srfc_pkg::POS_COMMAND : byte_count_reg;
    assign crc_base = (pos == srfc_pkg::POS_COMMAND) ? srfc_pkg::CRC_INIT : crc_reg;

    // next position wraps after the eighth byte
    always_comb begin
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        if (byte_accept) begin
            byte_count_next = pos + 3'd1;
            if (pos < srfc_pkg::CRC_SPAN) begin
                crc_next = srfc_pkg::crc16_absorb(crc_base, rx_byte);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= 3'd0;
            crc_reg        <= srfc_pkg::CRC_INIT;
        end else begin
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
        end
    end

    // field capture; every field is rewritten before a frame completes
    always_ff @(posedge aclk) begin
        if (byte_accept) begin
            case (pos)
                srfc_pkg::POS_COMMAND:   command_reg        <= rx_byte;
                srfc_pkg::POS_LENGTH:    length_reg         <= rx_byte;
                srfc_pkg::POS_HUM_HIGH:  raw_hum_reg[15:8]  <= rx_byte;
                srfc_pkg::POS_HUM_LOW:   raw_hum_reg[7:0]   <= rx_byte;
                srfc_pkg::POS_TEMP_HIGH: raw_temp_reg[15:8] <= rx_byte;
                srfc_pkg::POS_TEMP_LOW:  raw_temp_reg[7:0]  <= rx_byte;
                srfc_pkg::POS_CRC_LOW:   crc_low_reg        <= rx_byte;
                default: ;
            endcase
        end
    end

    // last byte: hand the whole frame to the checker
    assign rec_push = byte_accept && (pos == srfc_pkg::POS_CRC_HIGH);

    always_comb begin
        rec.command         = command_reg;
        rec.length          = length_reg;
        rec.raw_humidity    = raw_hum_reg;
        rec.raw_temperature = raw_temp_reg;
        rec.crc_calc        = crc_reg;
        rec.crc_recv        = {rx_byte, crc_low_reg};
    end

endmodule

/* rtl/core/srfc_queue.sv */
// Short queue of frame records between the front end and the checker.
// Depends on srfc_pkg.
`timescale 1ns / 1ps

module srfc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  srfc_pkg::frame_rec_t wr_data,
    output logic                 full,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output srfc_pkg::frame_rec_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    srfc_pkg::frame_rec_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rd_en;

    assign full     = (count_reg == CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_en    = rd_valid && rd_ready;
    assign rd_data  = entry_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // upstream must hold off while full
    assert property (@(posedge aclk) disable iff (!aresetn) !(wr_en && full))
        else $error("frame record pushed into a full queue");

    // fill count and pointers stay in step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg <= CNT_FULL) &&
        ((count_reg == '0 || count_reg == CNT_FULL) == (wr_ptr_reg == rd_ptr_reg)))
        else $error("queue fill count disagrees with pointers");

endmodule

/* rtl/core/srfc_back.sv */
// Checker: takes frame records from the queue, checks length, CRC and command,
// decodes good readings and holds the result register. Depends on srfc_pkg.
`timescale 1ns / 1ps

module srfc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  srfc_pkg::cfg_t       cfg,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  srfc_pkg::frame_rec_t q_rec,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_frame_ok,
    output logic [1:0]           m_status,
    output logic signed [15:0]   m_temperature_tenths,
    output logic signed [15:0]   m_humidity_tenths
);

    logic        valid_reg;
    logic        frame_ok_reg;
    logic [1:0]  status_reg;
    logic [15:0] last_temp_reg, last_temp_next;
    logic [15:0] last_hum_reg, last_hum_next;
    logic [1:0]  status_c;
    logic        pop;

    // result register is free or being drained
    assign q_ready = !valid_reg || m_ready;
    assign pop     = q_valid && q_ready;

    // checks in priority order: length, CRC, command
    always_comb begin
        if (q_rec.length != cfg.expected_length) begin
            status_c = srfc_pkg::STATUS_LENGTH;
        end else if (q_rec.crc_recv != q_rec.crc_calc) begin
            status_c = srfc_pkg::STATUS_CRC;
        end else if (q_rec.command != cfg.expected_command) begin
            status_c = srfc_pkg::STATUS_COMMAND;
        end else begin
            status_c = srfc_pkg::STATUS_OK;
        end
    end

    // stored readings move only on a good frame
    always_comb begin
        last_temp_next = last_temp_reg;
        last_hum_next  = last_hum_reg;
        if (pop && status_c == srfc_pkg::STATUS_OK) begin
            last_temp_next = srfc_pkg::decode_tenths(q_rec.raw_temperature);
            last_hum_next  = srfc_pkg::decode_tenths(q_rec.raw_humidity);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            last_temp_reg <= 16'd0;
            last_hum_reg  <= 16'd0;
        end else begin
            if (pop) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
            last_temp_reg <= last_temp_next;
            last_hum_reg  <= last_hum_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            frame_ok_reg <= (status_c == srfc_pkg::STATUS_OK);
            status_reg   <= status_c;
        end
    end

    assign m_valid              = valid_reg;
    assign m_frame_ok           = frame_ok_reg;
    assign m_status             = status_reg;
    assign m_temperature_tenths = signed'(last_temp_reg);
    assign m_humidity_tenths    = signed'(last_hum_reg);

    // ok flag and status code agree
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (frame_ok_reg == (status_reg == srfc_pkg::STATUS_OK)))
        else $error("frame_ok disagrees with status");

    // readings change only after a good frame was taken from the queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (!$stable(last_temp_reg) || !$stable(last_hum_reg)))
            |-> ($past(pop) && frame_ok_reg && valid_reg))
        else $error("stored readings changed without a good frame");

endmodule

/* rtl/core/sensor_response_frame_checker_unit.sv */
// Sensor response frame checker: top level with configuration registers.
// Depends on srfc_pkg, srfc_front, srfc_queue and srfc_back.
`timescale 1ns / 1ps

// Takes an eight-byte sensor read response one byte per transfer (command,
// length, humidity high/low, temperature high/low, CRC low/high) and gives one
// result per frame on its last byte: frame_ok, a status code (length, CRC and
// command checked in that order) and the stored temperature and humidity in
// signed tenths, updated only by good frames. frame_start restarts the frame
// at any byte. A byte is accepted every cycle while s_ready is high; the CRC
// over a byte is a single unrolled eight-step update in the front end, which
// allows that rate. The result register is fed by a QUEUE_DEPTH-entry queue
// of finished frames; s_ready drops only while it is full because results are
// not being taken. expected_command (index 0, reset 0x03) and expected_length
// (index 1, reset 0x04) are written through the cfg port; the user must write
// them only while no frame result is pending; the block does not enforce it.

module sensor_response_frame_checker_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration writes
    input  logic               cfg_write_enable,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_wdata,
    // received bytes
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_rx_byte,
    input  logic               s_frame_start,
    // frame results
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_frame_ok,
    output logic [1:0]         m_status,
    output logic signed [15:0] m_temperature_tenths,
    output logic signed [15:0] m_humidity_tenths
);

    logic [7:0]           expected_command_reg;
    logic [7:0]           expected_length_reg;
    srfc_pkg::cfg_t       cfg;
    logic                 byte_accept;
    logic                 rec_push;
    srfc_pkg::frame_rec_t push_rec;
    srfc_pkg::frame_rec_t pop_rec;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_command_reg <= srfc_pkg::EXPECTED_COMMAND_RESET;
            expected_length_reg  <= srfc_pkg::EXPECTED_LENGTH_RESET;
        end else if (cfg_write_enable) begin
            case (cfg_index)
                srfc_pkg::CFG_EXPECTED_COMMAND: expected_command_reg <= cfg_wdata;
                srfc_pkg::CFG_EXPECTED_LENGTH:  expected_length_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg.expected_command = expected_command_reg;
    assign cfg.expected_length  = expected_length_reg;

    // input transfer
    assign s_ready     = !q_full;
    assign byte_accept = s_valid && s_ready;

    srfc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_rx_byte),
        .frame_start (s_frame_start),
        .rec_push    (rec_push),
        .rec         (push_rec)
    );

    srfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (rec_push),
        .wr_data  (push_rec),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (pop_rec)
    );

    srfc_back u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg                  (cfg),
        .q_valid              (q_valid),
        .q_ready              (q_ready),
        .q_rec                (pop_rec),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_frame_ok           (m_frame_ok),
        .m_status             (m_status),
        .m_temperature_tenths (m_temperature_tenths),
        .m_humidity_tenths    (m_humidity_tenths)
    );

endmodule

/* verif/sensor_response_frame_checker_unit_test.sv */
// Self-checking testbench for the sensor response frame checker unit.
// Depends on srfc_pkg and sensor_response_frame_checker_unit; a scoreboard class
// predicts each frame result from the accepted bytes and checks the result channel.
`timescale 1ns / 1ps

module sensor_response_frame_checker_unit_test;

    localparam int QUIET_LIMIT   = 2000;  // cycles without any transfer before giving up
    localparam int SETTLE_CYCLES = 6;     // margin kept after the last awaited result
    localparam int LONG_HOLD     = 150;   // receiver hold-off, long enough to fill the queue
    localparam int PHASE_BYTES   = 200;

    typedef struct {
        logic              frame_ok;
        logic [1:0]        status;
        logic signed [15:0] temperature;
        logic signed [15:0] humidity;
    } frame_result_t;

    // Predicts frame results and holds those not yet seen on the result channel
    class frame_scoreboard;
        logic [7:0]    want_command;
        logic [7:0]    want_length;
        logic [2:0]    position;
        logic [15:0]   crc;
        logic [7:0]    command_byte;
        logic [7:0]    length_byte;
        logic [15:0]   humidity_raw;
        logic [15:0]   temperature_raw;
        logic [7:0]    crc_low;
        logic [15:0]   stored_temperature;
        logic [15:0]   stored_humidity;
        frame_result_t awaited_q[$];
        int            error_count;
        int            results_checked;

        function new();
            want_command       = 8'h03;
            want_length        = 8'h04;
            position           = 3'd0;
            crc                = 16'hFFFF;
            command_byte       = 8'h00;
            length_byte        = 8'h00;
            humidity_raw       = 16'h0000;
            temperature_raw    = 16'h0000;
            crc_low            = 8'h00;
            stored_temperature = 16'h0000;
            stored_humidity    = 16'h0000;
            error_count        = 0;
            results_checked    = 0;
        endfunction

        // reflected CRC-16, one bit per step
        static function logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
            logic [15:0] r;
            r = c;
            for (int i = 0; i < 8; i++) begin
                if (r[0] ^ b[i])
                    r = (r >> 1) ^ 16'hA001;
                else
                    r = r >> 1;
            end
            return r;
        endfunction

        // sign-magnitude tenths to two's complement
        function logic [15:0] to_tenths(input logic [15:0] raw);
            logic [15:0] magnitude;
            magnitude = {1'b0, raw[14:0]};
            return raw[15] ? (~magnitude + 16'd1) : magnitude;
        endfunction

        function void set_register(input logic idx, input logic [7:0] value);
            if (idx == srfc_pkg::CFG_EXPECTED_COMMAND)
                want_command = value;
            else
                want_length = value;
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        // one accepted byte transfer
        function void note_byte(input logic [7:0] b, input logic frame_start);
            logic [2:0]    pos;
            logic [1:0]    status;
            frame_result_t res;
            pos      = frame_start ? srfc_pkg::POS_COMMAND : position;
            position = pos + 3'd1;
            if (pos == srfc_pkg::POS_COMMAND)
                crc = 16'hFFFF;
            if (pos < srfc_pkg::CRC_SPAN)
                crc = crc_byte(crc, b);
            case (pos)
                srfc_pkg::POS_COMMAND:   command_byte = b;
                srfc_pkg::POS_LENGTH:    length_byte = b;
                srfc_pkg::POS_HUM_HIGH:  humidity_raw[15:8] = b;
                srfc_pkg::POS_HUM_LOW:   humidity_raw[7:0] = b;
                srfc_pkg::POS_TEMP_HIGH: temperature_raw[15:8] = b;
                srfc_pkg::POS_TEMP_LOW:  temperature_raw[7:0] = b;
                srfc_pkg::POS_CRC_LOW:   crc_low = b;
                default: begin
                    // last byte: checks in order length, CRC, command
                    if (length_byte != want_length)
                        status = srfc_pkg::STATUS_LENGTH;
                    else if ({b, crc_low} != crc)
                        status = srfc_pkg::STATUS_CRC;
                    else if (command_byte != want_command)
                        status = srfc_pkg::STATUS_COMMAND;
                    else
                        status = srfc_pkg::STATUS_OK;
                    if (status == srfc_pkg::STATUS_OK) begin
                        stored_temperature = to_tenths(temperature_raw);
                        stored_humidity    = to_tenths(humidity_raw);
                    end
                    res.frame_ok    = (status == srfc_pkg::STATUS_OK);
                    res.status      = status;
                    res.temperature = stored_temperature;
                    res.humidity    = stored_humidity;
                    awaited_q.push_back(res);
                end
            endcase
        endfunction

        task report_mismatch(input string what);
            error_count++;
            $display("[%0t] MISMATCH %s", $realtime, what);
        endtask

        task check_result(input frame_result_t got);
            frame_result_t want;
            results_checked++;
            if (awaited_q.size() == 0) begin
                report_mismatch($sformatf("result #%0d with nothing awaited", results_checked));
            end else begin
                want = awaited_q.pop_front();
                if (got.frame_ok !== want.frame_ok)
                    report_mismatch($sformatf("result #%0d frame_ok %b, want %b",
                        results_checked, got.frame_ok, want.frame_ok));
                if (got.status !== want.status)
                    report_mismatch($sformatf("result #%0d status %0d, want %0d",
                        results_checked, got.status, want.status));
                if (got.temperature !== want.temperature)
                    report_mismatch($sformatf("result #%0d temperature %0d, want %0d",
                        results_checked, got.temperature, want.temperature));
                if (got.humidity !== want.humidity)
                    report_mismatch($sformatf("result #%0d humidity %0d, want %0d",
                        results_checked, got.humidity, want.humidity));
            end
        endtask
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_write_enable = 1'b0;
    logic               cfg_index = 1'b0;
    logic [7:0]         cfg_wdata = 8'h00;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_rx_byte = 8'h00;
    logic               s_frame_start = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_frame_ok;
    logic [1:0]         m_status;
    logic signed [15:0] m_temperature_tenths;
    logic signed [15:0] m_humidity_tenths;

    frame_scoreboard board = new();
    int              bytes_sent = 0;
    int              quiet_cycles = 0;
    int              sink_stall = 0;
    bit              sink_burst = 1'b0;
    bit              long_hold_done = 1'b0;
    int              sink_cycle = 0;

    sensor_response_frame_checker_unit dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_write_enable     (cfg_write_enable),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_rx_byte            (s_rx_byte),
        .s_frame_start        (s_frame_start),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_frame_ok           (m_frame_ok),
        .m_status             (m_status),
        .m_temperature_tenths (m_temperature_tenths),
        .m_humidity_tenths    (m_humidity_tenths)
    );

    always #1 aclk = ~aclk;

    // mostly back to back, some short gaps, a few long ones
    function automatic int idle_len(input bit burst);
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // readings lean on the sign-magnitude corners
    function automatic logic [15:0] pick_reading();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'h8000;  // negative zero
            2:       return 16'h7FFF;
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // offer one byte and wait for its transfer
    task automatic send_byte(input logic [7:0] b, input logic frame_start, input bit burst);
        int gap;
        gap = idle_len(burst);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_rx_byte     <= b;
        s_frame_start <= frame_start;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_byte(b, frame_start);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] command, input logic [7:0] length,
                              input logic [15:0] humidity, input logic [15:0] temperature,
                              input logic [15:0] crc_flip, input logic first_start,
                              input bit burst);
        logic [7:0]  frame_bytes [8];
        logic [15:0] c;
        frame_bytes[0] = command;
        frame_bytes[1] = length;
        frame_bytes[2] = humidity[15:8];
        frame_bytes[3] = humidity[7:0];
        frame_bytes[4] = temperature[15:8];
        frame_bytes[5] = temperature[7:0];
        c = 16'hFFFF;
        for (int i = 0; i < 6; i++)
            c = frame_scoreboard::crc_byte(c, frame_bytes[i]);
        c = c ^ crc_flip;
        frame_bytes[6] = c[7:0];
        frame_bytes[7] = c[15:8];
        for (int i = 0; i < 8; i++)
            send_byte(frame_bytes[i], (i == 0) ? first_start : 1'b0, burst);
    endtask

    // well-formed frame against the live settings, with the odd fault mixed in
    task automatic send_random_frame();
        logic [7:0]  command;
        logic [7:0]  length;
        logic [15:0] flip;
        command = board.want_command;
        length  = board.want_length;
        flip    = 16'h0000;
        if ($urandom_range(0, 6) == 0)
            command = command ^ 8'($urandom_range(1, 255));
        if ($urandom_range(0, 6) == 0)
            length = length ^ 8'($urandom_range(1, 255));
        if ($urandom_range(0, 6) == 0)
            flip = 16'($urandom_range(1, 65535));
        send_frame(command, length, pick_reading(), pick_reading(), flip,
                   $urandom_range(0, 3) != 0, $urandom_range(0, 4) == 0);
    endtask

    // random bytes, occasionally flagged as a frame start
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 7);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0);
    endtask

    // sender pauses until every awaited result has arrived
    task automatic wait_results_done();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // both registers on consecutive edges, enable held high throughout
    task automatic write_config(input logic [7:0] command, input logic [7:0] length);
        cfg_write_enable <= 1'b1;
        cfg_index        <= srfc_pkg::CFG_EXPECTED_COMMAND;
        cfg_wdata        <= command;
        @(posedge aclk);
        cfg_index        <= srfc_pkg::CFG_EXPECTED_LENGTH;
        cfg_wdata        <= length;
        @(posedge aclk);
        cfg_write_enable <= 1'b0;
        board.set_register(srfc_pkg::CFG_EXPECTED_COMMAND, command);
        board.set_register(srfc_pkg::CFG_EXPECTED_LENGTH, length);
    endtask

    // result channel: random stalls, bursts of full rate, one long hold-off
    initial begin : result_sink
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            sink_cycle++;
            if (sink_cycle % 128 == 0)
                sink_burst = ($urandom_range(0, 3) == 0);
            if (!long_hold_done && board.results_checked >= 40) begin
                long_hold_done = 1'b1;
                sink_stall     = LONG_HOLD;
            end
            if (sink_stall > 0) begin
                m_ready <= 1'b0;
                sink_stall--;
            end else begin
                m_ready <= 1'b1;
                sink_stall = idle_len(sink_burst);
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        frame_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.frame_ok    = m_frame_ok;
            got.status      = m_status;
            got.temperature = m_temperature_tenths;
            got.humidity    = m_humidity_tenths;
            board.check_result(got);
        end
    end

    // watchdog on transfers of either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results awaited",
                     QUIET_LIMIT, board.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [7:0] rand_command;
        logic [7:0] rand_length;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed frames at the reset settings
        // good frame: negative zero humidity, most negative temperature
        send_frame(8'h03, 8'h04, 16'h8000, 16'hFFFF, 16'h0000, 1'b1, 1'b1);
        // partial frame cut short by a new frame start
        send_byte(8'h03, 1'b1, 1'b0);
        send_byte(8'h04, 1'b0, 1'b0);
        // bad length and bad CRC: length wins
        send_frame(8'h03, 8'h05, 16'h7FFF, 16'h7FFF, 16'h0100, 1'b1, 1'b0);
        // no start flag, relies on the count wrap; bad CRC and bad command: CRC wins
        send_frame(8'h07, 8'h04, 16'h0000, 16'h0001, 16'h0001, 1'b0, 1'b0);
        wait_results_done();

        // random phases over several settings, the extremes among them
        for (int phase = 0; phase < 5; phase++) begin
            rand_command = 8'($urandom_range(0, 255));
            rand_length  = 8'($urandom_range(0, 255));
            case (phase)
                0:       write_config(8'h00, 8'h00);
                1:       write_config(8'hFF, 8'hFF);
                4:       write_config(srfc_pkg::EXPECTED_COMMAND_RESET,
                                      srfc_pkg::EXPECTED_LENGTH_RESET);
                default: write_config(rand_command, rand_length);
            endcase
            bytes_sent = 0;
            while (bytes_sent < PHASE_BYTES) begin
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                else
                    send_random_frame();
            end
            wait_results_done();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (board.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sensor_response_frame_checker_unit.f */
rtl/core/srfc_pkg.sv
rtl/core/srfc_front.sv
rtl/core/srfc_queue.sv
rtl/core/srfc_back.sv
rtl/core/sensor_response_frame_checker_unit.sv
verif/sensor_response_frame_checker_unit_test.sv
